/* rtl/gtsp_pkg.sv */
package gtsp_pkg;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_COLON = 8'h3a;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;

   localparam logic [2:0] PREFIX_LEN  = 3'd3;
   localparam logic [2:0] PROC_MAX    = 3'd4;
   localparam logic [2:0] PROC_SHORT  = 3'd3;
   localparam logic [2:0] SRAMECC_LEN = 3'd7;
   localparam logic [2:0] XNACK_LEN   = 3'd5;
   localparam logic [4:0] MAJOR_TENS  = 5'd10;
   localparam logic [3:0] HEX_ALPHA_OFFSET = 4'd9;

   typedef enum logic [1:0] {
      PH_PREFIX,
      PH_PROC,
      PH_NAME,
      PH_SIGN
   } phase_type;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       last_char;
   } req_word_type;

   typedef struct packed {
      logic       valid_res;
      logic [4:0] major;
      logic [3:0] minor;
      logic [3:0] stepping;
   } rsp_word_type;

   typedef struct packed {
      phase_type       phase;
      logic [2:0]      position;
      logic [3:0][7:0] proc_chars;
      logic            match_sramecc;
      logic            match_xnack;
      logic            failed;
      logic            terminated;
   } parse_state_type;

   typedef struct packed {
      logic         fire;
      rsp_word_type word;
   } parse_result_type;

   function automatic logic is_dec(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
   endfunction

   // only called on a checked hex digit
   function automatic logic [3:0] hex_val(input logic [7:0] c);
      return is_dec(c) ? c[3:0] : c[3:0] + HEX_ALPHA_OFFSET;
   endfunction

   function automatic logic [7:0] prefix_char(input logic [1:0] idx);
      logic [7:0] r;
      unique case (idx)
         2'd0:    r = 8'h67;
         2'd1:    r = 8'h66;
         2'd2:    r = 8'h78;
         default: r = 8'hff;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] sramecc_char(input logic [2:0] idx);
      logic [7:0] r;
      unique case (idx)
         3'd0:    r = 8'h73;
         3'd1:    r = 8'h72;
         3'd2:    r = 8'h61;
         3'd3:    r = 8'h6d;
         3'd4:    r = 8'h65;
         3'd5:    r = 8'h63;
         3'd6:    r = 8'h63;
         default: r = 8'hff;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] xnack_char(input logic [2:0] idx);
      logic [7:0] r;
      unique case (idx)
         3'd0:    r = 8'h78;
         3'd1:    r = 8'h6e;
         3'd2:    r = 8'h61;
         3'd3:    r = 8'h63;
         3'd4:    r = 8'h6b;
         default: r = 8'hff;
      endcase
      return r;
   endfunction

endpackage

/* rtl/gtsp_parser.sv */
module gtsp_parser
   import gtsp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             take,
   input  req_word_type     req_word,
   output parse_result_type result
);

   parse_state_type state_ff;
   parse_state_type state_in;

   // check the processor field and bring it to four-character form
   function automatic parse_state_type close_proc(input parse_state_type s);
      parse_state_type r;
      r = s;
      if (s.position == PROC_SHORT) begin
         r.proc_chars = {s.proc_chars[2], s.proc_chars[1], s.proc_chars[0], CHAR_ZERO};
      end else if ((s.position != PROC_MAX) || (s.proc_chars[0] != CHAR_ONE)) begin
         r.failed = 1'b1;
         return r;
      end
      if (!is_dec(r.proc_chars[1]) || !is_dec(r.proc_chars[2]) || !is_hex(r.proc_chars[3]))
         r.failed = 1'b1;
      return r;
   endfunction

   function automatic parse_state_type start_name(input parse_state_type s);
      parse_state_type r;
      r = s;
      r.phase         = PH_NAME;
      r.position      = '0;
      r.match_sramecc = 1'b1;
      r.match_xnack   = 1'b1;
      return r;
   endfunction

   function automatic parse_state_type finish_text(input parse_state_type s);
      parse_state_type r;
      r = s;
      r.terminated = 1'b1;
      if (s.phase == PH_PROC)
         r = close_proc(r);
      else if (s.phase != PH_SIGN)
         r.failed = 1'b1;
      return r;
   endfunction

   function automatic parse_state_type step_byte(input parse_state_type s,
                                                 input logic [7:0] c);
      parse_state_type r;
      r = s;
      if (c == CHAR_NUL)
         return finish_text(s);
      unique case (s.phase)
         PH_PREFIX: begin
            if ((s.position >= PREFIX_LEN) || (c != prefix_char(s.position[1:0]))) begin
               r.failed = 1'b1;
            end else if (s.position == PREFIX_LEN - 3'd1) begin
               r.phase    = PH_PROC;
               r.position = '0;
            end else begin
               r.position = s.position + 3'd1;
            end
         end
         PH_PROC: begin
            if (c == CHAR_COLON) begin
               r = start_name(close_proc(s));
            end else if (s.position >= PROC_MAX) begin
               r.failed = 1'b1;
            end else begin
               r.proc_chars[s.position[1:0]] = c;
               r.position = s.position + 3'd1;
            end
         end
         PH_NAME: begin
            if ((c == CHAR_PLUS) || (c == CHAR_MINUS)) begin
               if ((s.match_sramecc && (s.position == SRAMECC_LEN)) ||
                   (s.match_xnack && (s.position == XNACK_LEN)))
                  r.phase = PH_SIGN;
               else
                  r.failed = 1'b1;
            end else if (c == CHAR_COLON) begin
               r.failed = 1'b1;
            end else begin
               r.match_sramecc = s.match_sramecc && (s.position < SRAMECC_LEN) &&
                                 (c == sramecc_char(s.position));
               r.match_xnack   = s.match_xnack && (s.position < XNACK_LEN) &&
                                 (c == xnack_char(s.position));
               if (s.position < SRAMECC_LEN)
                  r.position = s.position + 3'd1;
            end
         end
         PH_SIGN: begin
            if (c == CHAR_COLON)
               r = start_name(s);
            else
               r.failed = 1'b1;
         end
         default: r.failed = 1'b1;
      endcase
      return r;
   endfunction

   parse_state_type after_byte;
   parse_state_type after_end;

   always_comb begin
      after_byte = state_ff;
      after_end  = state_ff;
      state_in   = state_ff;
      result     = '0;
      if (take) begin
         if (!state_ff.terminated && !state_ff.failed)
            after_byte = step_byte(state_ff, req_word.char_byte);
         after_end = after_byte;
         if (req_word.last_char) begin
            if (!after_byte.terminated && !after_byte.failed)
               after_end = finish_text(after_byte);
            result.fire           = 1'b1;
            result.word.valid_res = !after_end.failed;
            if (!after_end.failed) begin
               result.word.major    = {1'b0, after_end.proc_chars[1][3:0]} +
                                      ((after_end.proc_chars[0] == CHAR_ONE) ? MAJOR_TENS : 5'd0);
               result.word.minor    = after_end.proc_chars[2][3:0];
               result.word.stepping = hex_val(after_end.proc_chars[3]);
            end
            // back to the idle state for the next text, stored field kept
            state_in               = after_end;
            state_in.phase         = PH_PREFIX;
            state_in.position      = '0;
            state_in.match_sramecc = 1'b1;
            state_in.match_xnack   = 1'b1;
            state_in.failed        = 1'b0;
            state_in.terminated    = 1'b0;
         end else begin
            state_in = after_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      state_ff.proc_chars <= state_in.proc_chars;
      if (reset) begin
         state_ff.phase         <= PH_PREFIX;
         state_ff.position      <= '0;
         state_ff.match_sramecc <= 1'b1;
         state_ff.match_xnack   <= 1'b1;
         state_ff.failed        <= 1'b0;
         state_ff.terminated    <= 1'b0;
      end else begin
         state_ff.phase         <= state_in.phase;
         state_ff.position      <= state_in.position;
         state_ff.match_sramecc <= state_in.match_sramecc;
         state_ff.match_xnack   <= state_in.match_xnack;
         state_ff.failed        <= state_in.failed;
         state_ff.terminated    <= state_in.terminated;
      end
   end

endmodule

/* rtl/gpu_target_string_parser_core.sv */
// target text parser: checks a target name streamed one byte per word
// req channel: one text byte per word plus a last flag on the final byte
// rsp channel: one verdict word per text (valid flag, major, minor, stepping),
//   numbers are zero when the text does not parse
// a zero byte ends the text early; bytes after it up to the last flag are dropped
// the verdict is registered into the output register or the skid entry
// throughput: one byte per cycle while req_stall is low, with a combinational step on the
//   state registers; a new text may start the cycle after the last byte
// a result register plus one skid entry sit on the output, so req keeps
//   flowing while a verdict waits; req_stall rises only once the skid entry
//   is occupied, and rsp_stall holds the shown verdict unchanged
// reset (synchronous, active high) returns the parser to the prefix phase and
//   empties the output stages; no verdict is lost or made up across stalls
module gpu_target_string_parser_core
   import gtsp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // byte input
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   // verdict output
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   parse_result_type result;
   logic             take;

   // output register and skid entry
   logic         out_valid_ff;
   logic         out_valid_in;
   rsp_word_type out_word_ff;
   rsp_word_type out_word_in;
   logic         skid_valid_ff;
   logic         skid_valid_in;
   rsp_word_type skid_word_ff;
   rsp_word_type skid_word_in;
   logic         out_free;

   assign req_stall = skid_valid_ff;
   assign take      = req_valid && !skid_valid_ff;

   gtsp_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .req_word (req_word),
      .result   (result)
   );

   // the output register can load when empty or being drained this cycle
   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      priority if (skid_valid_ff) begin
         // no new word while the skid entry is full
         if (out_free) begin
            out_valid_in  = 1'b1;
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end
      end else if (result.fire) begin
         if (out_free) begin
            out_valid_in = 1'b1;
            out_word_in  = result.word;
         end else begin
            skid_valid_in = 1'b1;
            skid_word_in  = result.word;
         end
      end else begin
         // nothing new: empty the output once its word is taken
         if (out_free)
            out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule
